[hw/rtl/skl_pkg.sv]
// skl_pkg: sizes, codes, entry layout and the structs passed between the
// modules of the sorted keyed list. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package skl_pkg;

	localparam int CAPACITY   = 32;
	localparam int NAME_BYTES = 30;

	localparam int KEY_W    = 32;
	localparam int WORD_W   = 64;
	localparam int WORD3_W  = 48;
	localparam int PAD_W    = 4 * WORD_W;
	localparam int NAME_W   = NAME_BYTES * 8;
	localparam int ENTRY_W  = KEY_W + NAME_W;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT    = 2'd0,
		CMD_DELETE    = 2'd1,
		CMD_LIST_ASC  = 2'd2,
		CMD_LIST_DESC = 2'd3
	} command_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_FULL      = 3'd1,
		ST_DELETED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EMPTY     = 3'd4,
		ST_LISTED    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_WALK,
		S_INS_LAST,
		S_DEL_WALK,
		S_LIST_OUT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [NAME_W-1:0] name;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} ram_wr_t;

	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] addr;
	} ram_rd_t;

	typedef struct packed {
		logic ge;
		logic eq;
	} cmp_t;

	typedef struct packed {
		status_t            status;
		logic [KEY_W-1:0]   entry_id;
		logic [WORD_W-1:0]  name_word0;
		logic [WORD_W-1:0]  name_word1;
		logic [WORD_W-1:0]  name_word2;
		logic [WORD3_W-1:0] name_word3;
		logic               final_item;
	} res_t;

	// Pack the four name words and drop bytes beyond NAME_BYTES.
	function automatic logic [NAME_W-1:0] to_name(
		input logic [WORD_W-1:0]  w0,
		input logic [WORD_W-1:0]  w1,
		input logic [WORD_W-1:0]  w2,
		input logic [WORD3_W-1:0] w3
	);
		logic [PAD_W-1:0] f;
		f = {{(WORD_W - WORD3_W){1'b0}}, w3, w2, w1, w0};
		return f[NAME_W-1:0];
	endfunction

	function automatic logic [PAD_W-1:0] from_name(input logic [NAME_W-1:0] n);
		logic [PAD_W-1:0] f;
		f = '0;
		f[NAME_W-1:0] = n;
		return f;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/skl_cmd_if.sv]
// skl_cmd_if: command channel (valid/ready plus command fields).
// Depends on skl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface skl_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [skl_pkg::CMD_W-1:0]       command;
	logic signed [skl_pkg::KEY_W-1:0] entry_id;
	logic [skl_pkg::WORD_W-1:0]      name_word0;
	logic [skl_pkg::WORD_W-1:0]      name_word1;
	logic [skl_pkg::WORD_W-1:0]      name_word2;
	logic [skl_pkg::WORD3_W-1:0]     name_word3;

	modport source (
		output valid, command, entry_id, name_word0, name_word1, name_word2, name_word3,
		input  ready
	);
	modport sink (
		input  valid, command, entry_id, name_word0, name_word1, name_word2, name_word3,
		output ready
	);
endinterface
`default_nettype wire

[hw/rtl/skl_res_if.sv]
// skl_res_if: result channel (valid/ready plus result fields).
// Depends on skl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface skl_res_if;
	logic                             valid;
	logic                             ready;
	logic [skl_pkg::STATUS_W-1:0]     status;
	logic signed [skl_pkg::KEY_W-1:0] entry_id_res;
	logic [skl_pkg::WORD_W-1:0]       name_word0_res;
	logic [skl_pkg::WORD_W-1:0]       name_word1_res;
	logic [skl_pkg::WORD_W-1:0]       name_word2_res;
	logic [skl_pkg::WORD3_W-1:0]      name_word3_res;
	logic                             final_item;

	modport source (
		output valid, status, entry_id_res, name_word0_res, name_word1_res,
			name_word2_res, name_word3_res, final_item,
		input  ready
	);
	modport sink (
		input  valid, status, entry_id_res, name_word0_res, name_word1_res,
			name_word2_res, name_word3_res, final_item,
		output ready
	);
endinterface
`default_nettype wire

[hw/rtl/sorted_keyed_list.sv]
// sorted_keyed_list: top level, wires sequencer, entry RAM, key compare unit
// and result register. Depends on skl_pkg, skl_cmd_if, skl_res_if and the skl_* modules.
//
// Usage:
//   cmd carries one command per transfer: insert, delete by ID, list ascending
//   or list descending. res carries the results; final_item marks the last
//   result of a command. Insert and delete give one result, a listing gives
//   one result per stored entry (one result with status empty if none).
//   Entries live in one RAM row each (ID plus name); the sequencer walks that
//   RAM through its single read port, one entry per cycle, with the shared
//   compare unit deciding each step.
//   Per command: insert walks down from the top shifting entries up, delete
//   searches and shifts down in one pass, and a full table insert, an empty
//   delete or an empty listing goes straight to its result.
//   A result is valid from the cycle after the sequencer's last step for it.
//   cmd.ready is high only while no command is in progress; a waiting result
//   sits in the output register and does not hold off the next command.
//   If the receiver stalls, a listing pauses on the current entry and resumes
//   where it left off; nothing is dropped.
//   Reset empties the table at once (entry count cleared); RAM contents are
//   not cleared and are only ever read below the entry count.
`timescale 1ns / 1ps
`default_nettype none
module sorted_keyed_list (
	input  logic      clk,
	input  logic      arst_n,
	skl_cmd_if.sink   cmd,
	skl_res_if.source res
);
	skl_pkg::ram_wr_t             ram_wr;
	skl_pkg::ram_rd_t             ram_rd;
	logic [skl_pkg::ENTRY_W-1:0]  rd_bits;
	skl_pkg::entry_t              rd_entry;
	logic [skl_pkg::KEY_W-1:0]    ref_key;
	skl_pkg::cmp_t                cmp;
	logic                         slot_free;
	logic                         out_load;
	skl_pkg::res_t                out_data;

	assign rd_entry = skl_pkg::entry_t'(rd_bits);

	skl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ram_wr    (ram_wr),
		.ram_rd    (ram_rd),
		.rd_entry  (rd_entry),
		.ref_key   (ref_key),
		.cmp       (cmp),
		.slot_free (slot_free),
		.out_load  (out_load),
		.out_data  (out_data)
	);

	skl_ram #(
		.WIDTH (skl_pkg::ENTRY_W),
		.DEPTH (skl_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_wr.we),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (ram_rd.re),
		.raddr (ram_rd.addr),
		.rdata (rd_bits)
	);

	skl_cmp u_cmp (
		.stored_key (rd_entry.key),
		.ref_key    (ref_key),
		.cmp        (cmp)
	);

	skl_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.data      (out_data),
		.slot_free (slot_free),
		.res       (res)
	);
endmodule
`default_nettype wire

[hw/rtl/skl_ram.sv]
// skl_ram: generic simple dual-port RAM, one write port, one read port with
// registered read data that holds while no read is issued. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module skl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

[hw/rtl/skl_cmp.sv]
// skl_cmp: shared key compare unit, signed greater-or-equal and equality.
// Depends on skl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module skl_cmp (
	input  logic [skl_pkg::KEY_W-1:0] stored_key,
	input  logic [skl_pkg::KEY_W-1:0] ref_key,
	output skl_pkg::cmp_t             cmp
);
	always_comb begin
		cmp.ge = ($signed(stored_key) >= $signed(ref_key));
		cmp.eq = (stored_key == ref_key);
	end
endmodule
`default_nettype wire

[hw/rtl/skl_out.sv]
// skl_out: output register on the result channel; frees its slot on the
// transfer so the next result can load in the same cycle. Depends on skl_pkg,
// skl_res_if.
`timescale 1ns / 1ps
`default_nettype none
module skl_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  skl_pkg::res_t    data,
	output logic             slot_free,
	skl_res_if.source        res
);
	logic          valid_q;
	skl_pkg::res_t data_q;

	assign slot_free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data;
		end
	end

	assign res.valid          = valid_q;
	assign res.status         = data_q.status;
	assign res.entry_id_res   = data_q.entry_id;
	assign res.name_word0_res = data_q.name_word0;
	assign res.name_word1_res = data_q.name_word1;
	assign res.name_word2_res = data_q.name_word2;
	assign res.name_word3_res = data_q.name_word3;
	assign res.final_item     = data_q.final_item;
endmodule
`default_nettype wire

[hw/rtl/skl_ctrl.sv]
// skl_ctrl: sequencer that walks the entry RAM one entry per cycle, a listing
// pausing while the result slot is taken, for insert (shift up from the top),
// delete (search and shift down) and listing. Depends on skl_pkg, skl_cmd_if.
`timescale 1ns / 1ps
`default_nettype none
module skl_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	skl_cmd_if.sink                   cmd,
	output skl_pkg::ram_wr_t          ram_wr,
	output skl_pkg::ram_rd_t          ram_rd,
	input  skl_pkg::entry_t           rd_entry,
	output logic [skl_pkg::KEY_W-1:0] ref_key,
	input  skl_pkg::cmp_t             cmp,
	input  logic                      slot_free,
	output logic                      out_load,
	output skl_pkg::res_t             out_data
);
	localparam int IDX_W = skl_pkg::IDX_W;
	localparam int CNT_W = skl_pkg::CNT_W;

	skl_pkg::state_t  state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             found_q, found_d;
	logic             desc_q, desc_d;
	skl_pkg::status_t resp_q, resp_d;
	logic [skl_pkg::KEY_W-1:0] resp_id_q, resp_id_d;
	skl_pkg::entry_t  new_q, new_in;

	skl_pkg::command_t    cmd_code;
	logic [IDX_W-1:0]     last_idx;
	logic                 is_full, is_empty, list_last, transfer;
	logic [skl_pkg::PAD_W-1:0] rd_name;

	assign cmd_code  = skl_pkg::command_t'(cmd.command);
	assign last_idx  = IDX_W'(cnt_q - 1'b1);
	assign is_full   = (cnt_q == CNT_W'(skl_pkg::CAPACITY));
	assign is_empty  = (cnt_q == '0);
	assign list_last = desc_q ? (idx_q == '0) : (idx_q == last_idx);
	assign transfer  = cmd.valid && (state_q == skl_pkg::S_IDLE);
	assign rd_name   = skl_pkg::from_name(rd_entry.name);
	assign ref_key   = new_q.key;
	assign cmd.ready = (state_q == skl_pkg::S_IDLE);

	always_comb begin
		new_in.key  = cmd.entry_id;
		new_in.name = skl_pkg::to_name(cmd.name_word0, cmd.name_word1,
			cmd.name_word2, cmd.name_word3);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			skl_pkg::S_IDLE: begin
				if (cmd.valid) begin
					unique case (cmd_code)
						skl_pkg::CMD_INSERT:
							state_d = (is_full || is_empty) ? skl_pkg::S_RESP
								: skl_pkg::S_INS_WALK;
						skl_pkg::CMD_DELETE:
							state_d = is_empty ? skl_pkg::S_RESP : skl_pkg::S_DEL_WALK;
						default:
							state_d = is_empty ? skl_pkg::S_RESP : skl_pkg::S_LIST_OUT;
					endcase
				end
			end
			skl_pkg::S_INS_WALK: begin
				if (!cmp.ge) begin
					state_d = skl_pkg::S_RESP;
				end else if (idx_q == '0) begin
					state_d = skl_pkg::S_INS_LAST;
				end
			end
			skl_pkg::S_INS_LAST: state_d = skl_pkg::S_RESP;
			skl_pkg::S_DEL_WALK: begin
				if (idx_q == last_idx) begin
					state_d = skl_pkg::S_RESP;
				end
			end
			skl_pkg::S_LIST_OUT: begin
				if (slot_free && list_last) begin
					state_d = skl_pkg::S_IDLE;
				end
			end
			skl_pkg::S_RESP: begin
				if (slot_free) begin
					state_d = skl_pkg::S_IDLE;
				end
			end
			default: state_d = skl_pkg::S_IDLE;
		endcase
	end

	// outputs and datapath next values
	always_comb begin
		ram_wr.we   = 1'b0;
		ram_wr.addr = '0;
		ram_wr.data = new_q;
		ram_rd.re   = 1'b0;
		ram_rd.addr = '0;
		out_load    = 1'b0;
		out_data.status     = resp_q;
		out_data.entry_id   = resp_id_q;
		out_data.name_word0 = '0;
		out_data.name_word1 = '0;
		out_data.name_word2 = '0;
		out_data.name_word3 = '0;
		out_data.final_item = 1'b1;
		idx_d     = idx_q;
		cnt_d     = cnt_q;
		found_d   = found_q;
		desc_d    = desc_q;
		resp_d    = resp_q;
		resp_id_d = resp_id_q;

		unique case (state_q)
			skl_pkg::S_IDLE: begin
				if (cmd.valid) begin
					resp_id_d = cmd.entry_id;
					unique case (cmd_code)
						skl_pkg::CMD_INSERT: begin
							resp_d = skl_pkg::ST_INSERTED;
							if (is_full) begin
								resp_d = skl_pkg::ST_FULL;
							end else if (is_empty) begin
								ram_wr.we   = 1'b1;
								ram_wr.data = new_in;
								cnt_d       = CNT_W'(cnt_q + 1'b1);
							end else begin
								ram_rd.re   = 1'b1;
								ram_rd.addr = last_idx;
								idx_d       = last_idx;
							end
						end
						skl_pkg::CMD_DELETE: begin
							resp_d  = skl_pkg::ST_EMPTY;
							found_d = 1'b0;
							idx_d   = '0;
							ram_rd.re = !is_empty;
						end
						default: begin
							resp_d    = skl_pkg::ST_EMPTY;
							resp_id_d = '0;
							desc_d    = (cmd_code == skl_pkg::CMD_LIST_DESC);
							idx_d     = desc_d ? last_idx : '0;
							ram_rd.re   = !is_empty;
							ram_rd.addr = idx_d;
						end
					endcase
				end
			end
			skl_pkg::S_INS_WALK: begin
				// entries at or above the new key move up one slot
				ram_wr.we   = 1'b1;
				ram_wr.addr = IDX_W'(idx_q + 1'b1);
				if (cmp.ge) begin
					ram_wr.data = rd_entry;
					if (idx_q != '0) begin
						ram_rd.re   = 1'b1;
						ram_rd.addr = IDX_W'(idx_q - 1'b1);
						idx_d       = IDX_W'(idx_q - 1'b1);
					end
				end else begin
					cnt_d = CNT_W'(cnt_q + 1'b1);
				end
			end
			skl_pkg::S_INS_LAST: begin
				ram_wr.we = 1'b1;
				cnt_d     = CNT_W'(cnt_q + 1'b1);
			end
			skl_pkg::S_DEL_WALK: begin
				found_d = found_q || cmp.eq;
				// after the first match every entry moves down one slot
				if (found_q) begin
					ram_wr.we   = 1'b1;
					ram_wr.addr = IDX_W'(idx_q - 1'b1);
					ram_wr.data = rd_entry;
				end
				if (idx_q == last_idx) begin
					resp_d = found_d ? skl_pkg::ST_DELETED : skl_pkg::ST_NOT_FOUND;
					if (found_d) begin
						cnt_d = CNT_W'(cnt_q - 1'b1);
					end
				end else begin
					ram_rd.re   = 1'b1;
					ram_rd.addr = IDX_W'(idx_q + 1'b1);
					idx_d       = IDX_W'(idx_q + 1'b1);
				end
			end
			skl_pkg::S_LIST_OUT: begin
				out_data.status     = skl_pkg::ST_LISTED;
				out_data.entry_id   = rd_entry.key;
				out_data.name_word0 = rd_name[0 +: skl_pkg::WORD_W];
				out_data.name_word1 = rd_name[skl_pkg::WORD_W +: skl_pkg::WORD_W];
				out_data.name_word2 = rd_name[2 * skl_pkg::WORD_W +: skl_pkg::WORD_W];
				out_data.name_word3 = rd_name[3 * skl_pkg::WORD_W +: skl_pkg::WORD3_W];
				out_data.final_item = list_last;
				if (slot_free) begin
					out_load = 1'b1;
					if (!list_last) begin
						idx_d       = desc_q ? IDX_W'(idx_q - 1'b1) : IDX_W'(idx_q + 1'b1);
						ram_rd.re   = 1'b1;
						ram_rd.addr = idx_d;
					end
				end
			end
			skl_pkg::S_RESP: begin
				out_load = slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skl_pkg::S_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
			found_q <= 1'b0;
			desc_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			found_q <= found_d;
			desc_q  <= desc_d;
		end
	end

	always_ff @(posedge clk) begin
		resp_q    <= resp_d;
		resp_id_q <= resp_id_d;
		if (transfer) begin
			new_q <= new_in;
		end
	end
endmodule
`default_nettype wire

[hw/rtl/skl_checker.sv]
// skl_checker: port-level checks of the sorted keyed list, attached to the
// top level by the bind below. Depends on skl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module skl_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cmd_valid,
	input logic                         cmd_ready,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [skl_pkg::STATUS_W-1:0] res_status,
	input logic                         res_final_item
);
	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status)
			&& $stable(res_final_item))
	else $error("stalled result changed");

	// only listed entries can be followed by more results
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status != skl_pkg::ST_LISTED) |-> res_final_item)
	else $error("non-listing result not marked final");

	// ready is low in the cycle after every command transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
	else $error("ready straight after a command transfer");

	// while idle, a waiting result is the last one of its command
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && cmd_ready |-> res_final_item)
	else $error("idle with a non-final result pending");
endmodule

bind sorted_keyed_list skl_checker u_skl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_status     (res.status),
	.res_final_item (res.final_item)
);
`default_nettype wire
